// ===== rtl/core/fmc_pkg.sv =====
// fmc_pkg: shared constants, command and status codes, request and response types
// for the paired fifo matcher; no dependencies
package fmc_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int ID_BITS     = 16;

	localparam int FIELD_W = 16;
	localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W   = PTR_W + 1;

	localparam logic [1:0] CMD_ADD_RIDER  = 2'd0;
	localparam logic [1:0] CMD_ADD_DRIVER = 2'd1;
	localparam logic [1:0] CMD_MATCH      = 2'd2;
	localparam logic [1:0] CMD_CANCEL     = 2'd3;

	localparam logic [1:0] STAT_DONE    = 2'd0;
	localparam logic [1:0] STAT_MATCHED = 2'd1;
	localparam logic [1:0] STAT_NO_PAIR = 2'd2;
	localparam logic [1:0] STAT_FULL    = 2'd3;

	typedef logic [ID_BITS-1:0] id_t;
	typedef logic [PTR_W-1:0]   ptr_t;
	typedef logic [CNT_W-1:0]   cnt_t;

	typedef struct packed {
		logic [1:0]         command;
		logic [FIELD_W-1:0] entity_id;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [FIELD_W-1:0] driver_id;
		logic [FIELD_W-1:0] rider_id;
	} rsp_t;

endpackage

// ===== rtl/core/paired_fifo_matcher_with_cancel.sv =====
// paired_fifo_matcher_with_cancel: top level, command sequencer and queue state
// depends on fmc_pkg, fmc_ram, fmc_unit
//
// Two circular queues of ids (riders, drivers) sit in two rams of QUEUE_DEPTH
// entries each. One request is taken at a time; req_ready is high while the
// sequencer is idle, even if a response still waits on rsp. An add or a match
// with an empty queue goes from EXEC straight to RESP, a match that pairs passes
// through MREAD, and a cancel passes through SCAN: the cancel walks the rider
// queue one entry per cycle through the rider ram read port and the shared
// comparator, writing each younger entry one place down once the id has been
// found. A response held back by rsp_ready stalls the next response.
module paired_fifo_matcher_with_cancel
	import fmc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_MREAD = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_RESP  = 3'd4;

	logic [2:0] state_q;
	logic [1:0] cmd_q;
	id_t        id_q;
	ptr_t       r_head_q;
	ptr_t       d_head_q;
	cnt_t       r_count_q;
	cnt_t       d_count_q;
	cnt_t       scan_i_q;
	logic       rd_v_q;
	logic       found_q;
	ptr_t       rd_addr_s1;
	ptr_t       last_addr_q;
	rsp_t       res_q;
	rsp_t       rsp_q;
	logic       rsp_valid_q;

	ptr_t       u_base;
	cnt_t       u_offset;
	ptr_t       u_addr;
	logic       u_eq;

	logic       r_we;
	ptr_t       r_waddr;
	id_t        r_wdata;
	ptr_t       r_raddr;
	id_t        r_rdata;
	logic       d_we;
	id_t        d_rdata;

	logic       r_full;
	logic       d_full;
	logic       scan_issue;
	logic       scan_done;
	logic       rsp_free;

	assign r_full     = (r_count_q == CNT_W'(QUEUE_DEPTH));
	assign d_full     = (d_count_q == CNT_W'(QUEUE_DEPTH));
	assign scan_issue = (state_q == S_SCAN) && (scan_i_q < r_count_q);
	assign scan_done  = (state_q == S_SCAN) && !scan_issue && !rd_v_q;
	assign rsp_free   = !rsp_valid_q || rsp_ready;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// shared unit operand select
	always_comb begin
		u_base   = r_head_q;
		u_offset = scan_i_q;
		if (state_q == S_EXEC && cmd_q == CMD_ADD_DRIVER) begin
			u_base   = d_head_q;
			u_offset = d_count_q;
		end else if (state_q == S_EXEC && cmd_q == CMD_ADD_RIDER) begin
			u_offset = r_count_q;
		end
	end

	fmc_unit u_unit (
		.base   (u_base),
		.offset (u_offset),
		.id_a   (r_rdata),
		.id_b   (id_q),
		.addr   (u_addr),
		.eq     (u_eq)
	);

	always_comb begin
		r_we    = 1'b0;
		r_waddr = u_addr;
		r_wdata = id_q;
		if (state_q == S_EXEC && cmd_q == CMD_ADD_RIDER && !r_full) begin
			r_we = 1'b1;
		end else if (state_q == S_SCAN && rd_v_q && found_q) begin
			r_we    = 1'b1;
			r_waddr = last_addr_q;
			r_wdata = r_rdata;
		end
		r_raddr = (state_q == S_SCAN) ? u_addr : r_head_q;
		d_we    = (state_q == S_EXEC) && (cmd_q == CMD_ADD_DRIVER) && !d_full;
	end

	fmc_ram #(
		.WIDTH (ID_BITS),
		.DEPTH (QUEUE_DEPTH)
	) u_rider_ram (
		.clk   (clk),
		.we    (r_we),
		.waddr (r_waddr),
		.wdata (r_wdata),
		.raddr (r_raddr),
		.rdata (r_rdata)
	);

	fmc_ram #(
		.WIDTH (ID_BITS),
		.DEPTH (QUEUE_DEPTH)
	) u_driver_ram (
		.clk   (clk),
		.we    (d_we),
		.waddr (u_addr),
		.wdata (id_q),
		.raddr (d_head_q),
		.rdata (d_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			r_head_q    <= '0;
			d_head_q    <= '0;
			r_count_q   <= '0;
			d_count_q   <= '0;
			scan_i_q    <= '0;
			rd_v_q      <= 1'b0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == S_RESP && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					scan_i_q <= '0;
					rd_v_q   <= 1'b0;
					found_q  <= 1'b0;
					unique case (cmd_q)
						CMD_ADD_RIDER: begin
							if (!r_full) begin
								r_count_q <= r_count_q + CNT_W'(1);
							end
							state_q <= S_RESP;
						end
						CMD_ADD_DRIVER: begin
							if (!d_full) begin
								d_count_q <= d_count_q + CNT_W'(1);
							end
							state_q <= S_RESP;
						end
						CMD_MATCH: begin
							if (r_count_q == '0 || d_count_q == '0) begin
								state_q <= S_RESP;
							end else begin
								state_q <= S_MREAD;
							end
						end
						CMD_CANCEL: begin
							state_q <= S_SCAN;
						end
						default: begin
							state_q <= S_RESP;
						end
					endcase
				end
				S_MREAD: begin
					r_head_q  <= (r_head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0
						: r_head_q + PTR_W'(1);
					d_head_q  <= (d_head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0
						: d_head_q + PTR_W'(1);
					r_count_q <= r_count_q - CNT_W'(1);
					d_count_q <= d_count_q - CNT_W'(1);
					state_q   <= S_RESP;
				end
				S_SCAN: begin
					rd_v_q <= scan_issue;
					if (scan_issue) begin
						scan_i_q <= scan_i_q + CNT_W'(1);
					end
					if (rd_v_q && !found_q && u_eq) begin
						found_q <= 1'b1;
					end
					if (scan_done) begin
						if (found_q) begin
							r_count_q <= r_count_q - CNT_W'(1);
						end
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			cmd_q <= req.command;
			id_q  <= req.entity_id[ID_BITS-1:0];
		end
		if (scan_issue) begin
			rd_addr_s1 <= u_addr;
		end
		if (state_q == S_SCAN && rd_v_q) begin
			last_addr_q <= rd_addr_s1;
		end
		if (state_q == S_EXEC) begin
			res_q.driver_id <= '0;
			res_q.rider_id  <= '0;
			if (cmd_q == CMD_ADD_RIDER && r_full) begin
				res_q.status <= STAT_FULL;
			end else if (cmd_q == CMD_ADD_DRIVER && d_full) begin
				res_q.status <= STAT_FULL;
			end else if (cmd_q == CMD_MATCH) begin
				res_q.status <= STAT_NO_PAIR;
			end else begin
				res_q.status <= STAT_DONE;
			end
		end
		if (state_q == S_MREAD) begin
			res_q.status    <= STAT_MATCHED;
			res_q.driver_id <= FIELD_W'(d_rdata);
			res_q.rider_id  <= FIELD_W'(r_rdata);
		end
		if (state_q == S_RESP && rsp_free) begin
			rsp_q <= res_q;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(r_count_q <= CNT_W'(QUEUE_DEPTH)) && (d_count_q <= CNT_W'(QUEUE_DEPTH)))
		else $error("queue count above depth");

	a_match_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MREAD) |-> (r_count_q != '0 && d_count_q != '0))
		else $error("match pop from empty queue");

	a_scan_write_after_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && r_we) |-> found_q)
		else $error("rider ram written before cancel hit");

	a_resp_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP && rsp_free) |=> (rsp_valid_q && state_q == S_IDLE))
		else $error("response not issued");
`endif

endmodule

// ===== rtl/core/fmc_ram.sv =====
// fmc_ram: generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module fmc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/fmc_unit.sv =====
// fmc_unit: shared circular address adder and id comparator
// depends on fmc_pkg
module fmc_unit
	import fmc_pkg::*;
(
	input  ptr_t base,
	input  cnt_t offset,
	input  id_t  id_a,
	input  id_t  id_b,
	output ptr_t addr,
	output logic eq
);

	logic [SUM_W-1:0] sum;
	logic [SUM_W-1:0] wrapped;

	always_comb begin
		sum     = SUM_W'(base) + SUM_W'(offset);
		wrapped = sum - SUM_W'(QUEUE_DEPTH);
		if (sum >= SUM_W'(QUEUE_DEPTH)) begin
			addr = wrapped[PTR_W-1:0];
		end else begin
			addr = sum[PTR_W-1:0];
		end
		eq = (id_a == id_b);
	end

endmodule

// ===== bench/tb_paired_fifo_matcher_with_cancel.sv =====
// tb_paired_fifo_matcher_with_cancel: self-checking bench for the paired fifo matcher,
// with directed, full-queue and random request phases under varied idling and stalls
// depends on fmc_pkg and paired_fifo_matcher_with_cancel
module tb_paired_fifo_matcher_with_cancel;
	import fmc_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	id_t riders_waiting[$];
	id_t drivers_waiting[$];
	rsp_t expected_rsp[$];

	int errors = 0;
	int n_requests = 0;
	int n_matched = 0;
	int n_no_pair = 0;
	int n_full = 0;
	int n_cancel_hit = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;

	paired_fifo_matcher_with_cancel dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= stall_pct);
	end

	// updates the queue picture for one request and returns its response
	function automatic rsp_t queue_response(input req_t r);
		rsp_t o;
		id_t id;
		int pos;
		o = '0;
		o.status = STAT_DONE;
		id = r.entity_id[ID_BITS-1:0];
		pos = -1;
		case (r.command)
			CMD_ADD_RIDER: begin
				if (riders_waiting.size() >= QUEUE_DEPTH) begin
					o.status = STAT_FULL;
					n_full++;
				end else begin
					riders_waiting.push_back(id);
				end
			end
			CMD_ADD_DRIVER: begin
				if (drivers_waiting.size() >= QUEUE_DEPTH) begin
					o.status = STAT_FULL;
					n_full++;
				end else begin
					drivers_waiting.push_back(id);
				end
			end
			CMD_MATCH: begin
				if (riders_waiting.size() == 0 || drivers_waiting.size() == 0) begin
					o.status = STAT_NO_PAIR;
					n_no_pair++;
				end else begin
					o.status = STAT_MATCHED;
					o.driver_id = FIELD_W'(drivers_waiting.pop_front());
					o.rider_id = FIELD_W'(riders_waiting.pop_front());
					n_matched++;
				end
			end
			default: begin
				// oldest rider with this id leaves
				foreach (riders_waiting[i]) begin
					if (pos < 0 && riders_waiting[i] == id)
						pos = i;
				end
				if (pos >= 0) begin
					riders_waiting.delete(pos);
					n_cancel_hit++;
				end
			end
		endcase
		return o;
	endfunction

	function automatic logic [FIELD_W-1:0] any_waiting_rider();
		return FIELD_W'(riders_waiting[$urandom_range(riders_waiting.size() - 1)]);
	endfunction

	task automatic send_request(input logic [1:0] cmd, input logic [FIELD_W-1:0] id);
		req_t r;
		r.command = cmd;
		r.entity_id = id;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
		expected_rsp.push_back(queue_response(r));
		n_requests++;
	endtask

	task automatic wait_for_drain();
		req_valid <= 1'b0;
		while (expected_rsp.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin : check_rsp
		rsp_t e;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_rsp.size() == 0) begin
				errors++;
				$error("response with no request pending: status %0d driver_id %h rider_id %h",
					rsp.status, rsp.driver_id, rsp.rider_id);
			end else begin
				e = expected_rsp.pop_front();
				if (rsp.status !== e.status) begin
					errors++;
					$error("status: expected %0d actual %0d", e.status, rsp.status);
				end
				if (rsp.driver_id !== e.driver_id) begin
					errors++;
					$error("driver_id: expected %h actual %h", e.driver_id, rsp.driver_id);
				end
				if (rsp.rider_id !== e.rider_id) begin
					errors++;
					$error("rider_id: expected %h actual %h", e.rider_id, rsp.rider_id);
				end
			end
		end
	end

	task automatic test_directed();
		send_request(CMD_MATCH, 16'h0000);
		send_request(CMD_CANCEL, 16'h0000);
		send_request(CMD_ADD_RIDER, 16'h0000);
		send_request(CMD_MATCH, 16'hFFFF);
		send_request(CMD_ADD_DRIVER, 16'hFFFF);
		send_request(CMD_MATCH, 16'h0000);
		send_request(CMD_ADD_DRIVER, 16'h0000);
		send_request(CMD_MATCH, 16'h0000);
		send_request(CMD_ADD_RIDER, 16'hFFFF);
		send_request(CMD_MATCH, 16'h0000);
		send_request(CMD_ADD_RIDER, 16'h1234);
		send_request(CMD_ADD_RIDER, 16'hA5A5);
		send_request(CMD_ADD_RIDER, 16'h1234);
		send_request(CMD_ADD_RIDER, 16'h5A5A);
		// repeated id, then absent id, then tail
		send_request(CMD_CANCEL, 16'h1234);
		send_request(CMD_CANCEL, 16'hBEEF);
		send_request(CMD_CANCEL, 16'h5A5A);
		send_request(CMD_ADD_DRIVER, 16'h8001);
		send_request(CMD_MATCH, 16'h0000);
		send_request(CMD_CANCEL, 16'h1234);
		send_request(CMD_MATCH, 16'hC3C3);
		wait_for_drain();
	endtask

	task automatic test_full_queues();
		repeat (QUEUE_DEPTH + 2)
			send_request(CMD_ADD_RIDER, FIELD_W'($urandom_range(65535)));
		repeat (QUEUE_DEPTH + 2)
			send_request(CMD_ADD_DRIVER, FIELD_W'($urandom_range(65535)));
		send_request(CMD_CANCEL, FIELD_W'(riders_waiting[0]));
		send_request(CMD_CANCEL, FIELD_W'(riders_waiting[riders_waiting.size() - 1]));
		send_request(CMD_CANCEL, any_waiting_rider());
		repeat (4)
			send_request(CMD_ADD_RIDER, FIELD_W'($urandom_range(65535)));
		repeat (QUEUE_DEPTH + 1)
			send_request(CMD_MATCH, FIELD_W'($urandom_range(65535)));
		wait_for_drain();
	endtask

	task automatic test_random(input int n);
		logic [1:0] cmd;
		logic [FIELD_W-1:0] id;
		bit grow;
		int add_w;
		int r;
		grow = 1'b1;
		for (int i = 0; i < n; i++) begin
			if (i % 80 == 0)
				grow = ($urandom_range(1) != 0);
			add_w = grow ? 70 : 30;
			r = $urandom_range(99);
			id = FIELD_W'($urandom_range(65535));
			if (r < add_w) begin
				cmd = ($urandom_range(1) != 0) ? CMD_ADD_DRIVER : CMD_ADD_RIDER;
				if (cmd == CMD_ADD_RIDER && riders_waiting.size() > 0 && $urandom_range(9) == 0)
					id = any_waiting_rider();
			end else if (r < add_w + (100 - add_w) / 2) begin
				cmd = CMD_MATCH;
			end else begin
				cmd = CMD_CANCEL;
				if (riders_waiting.size() > 0 && $urandom_range(3) != 0)
					id = any_waiting_rider();
			end
			send_request(cmd, id);
		end
		wait_for_drain();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		send_idle_pct = 24;
		stall_pct = 24;
		test_full_queues();

		send_idle_pct = 0;
		stall_pct = 0;
		test_random(155);
		send_idle_pct = 48;
		stall_pct = 0;
		test_random(155);
		send_idle_pct = 0;
		stall_pct = 48;
		test_random(155);
		send_idle_pct = 24;
		stall_pct = 24;
		test_random(155);

		wait_for_drain();
		repeat (100) @(posedge clk);
		$display("covered %0d requests: %0d pairs matched, %0d no-pair, %0d adds dropped full,",
			n_requests, n_matched, n_no_pair, n_full);
		$display("%0d riders cancelled, under free flow, sender gaps and receiver stalls",
			n_cancel_hit);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
